[rtl/core/trb_pkg.sv]
// Shared types, codes and constants for the trace ring with repeat collapse.
`default_nettype none
package trb_pkg;

  localparam int DEFAULT_RING_DEPTH = 128;

  localparam logic [2:0] OP_CMD   = 3'd0;
  localparam logic [2:0] OP_MSG   = 3'd1;
  localparam logic [2:0] OP_EVT   = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] KIND_COMMAND = 2'd0;
  localparam logic [1:0] KIND_MESSAGE = 2'd1;
  localparam logic [1:0] KIND_EVENT   = 2'd2;

  localparam logic [15:0] REPEAT_LIMIT = 16'hffff;

  // One stored trace entry as it leaves or enters the ring memory.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] stamp;
    logic [7:0]  cls;
    logic [7:0]  ins;
    logic [7:0]  pa;
    logic [7:0]  pb;
    logic [15:0] status;
    logic [15:0] rep_count;
    logic [15:0] event_code;
  } entry_t;

  // Write strobes: a new slot writes everything, a collapse only time, status and repeat.
  typedef struct packed {
    logic we;
    logic hdr_we;
  } wr_req_t;

  // Read status handed from the controller to the output stage.
  typedef struct packed {
    logic       pending;
    logic       hit;
    logic [7:0] used;
  } read_info_t;

endpackage
`default_nettype wire

[rtl/core/trb_ring_mem.sv]
// Ring storage: synchronous memories with one write port and one registered read port.
`default_nettype none
module trb_ring_mem import trb_pkg::*; #(
  parameter int DEPTH = DEFAULT_RING_DEPTH,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire wr_req_t          wr,
  input  wire logic [PTR_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic             rd_en,
  input  wire logic [PTR_W-1:0] rd_addr,
  output entry_t                rd_data
);

  logic [31:0] time_mem   [DEPTH];
  logic [33:0] header_mem [DEPTH];
  logic [31:0] sr_mem     [DEPTH];
  logic [15:0] event_mem  [DEPTH];

  logic [31:0] stamp_q;
  logic [33:0] hdr_q;
  logic [31:0] sr_q;
  logic [15:0] event_q;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      time_mem[wr_addr] <= wr_data.stamp;
      sr_mem[wr_addr]   <= {wr_data.status, wr_data.rep_count};
    end
    if (wr.hdr_we) begin
      header_mem[wr_addr] <= {wr_data.kind, wr_data.cls, wr_data.ins, wr_data.pa, wr_data.pb};
      event_mem[wr_addr]  <= wr_data.event_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      stamp_q <= time_mem[rd_addr];
      hdr_q   <= header_mem[rd_addr];
      sr_q    <= sr_mem[rd_addr];
      event_q <= event_mem[rd_addr];
    end
  end

  always_comb begin
    rd_data.kind       = hdr_q[33:32];
    rd_data.stamp      = stamp_q;
    rd_data.cls        = hdr_q[31:24];
    rd_data.ins        = hdr_q[23:16];
    rd_data.pa         = hdr_q[15:8];
    rd_data.pb         = hdr_q[7:0];
    rd_data.status     = sr_q[31:16];
    rd_data.rep_count  = sr_q[15:0];
    rd_data.event_code = event_q;
  end

endmodule
`default_nettype wire

[rtl/core/trb_ctrl.sv]
// Ring controller: pointers, fill count, newest-entry copy, collapse decision and read address.
`default_nettype none
module trb_ctrl import trb_pkg::*; #(
  parameter int DEPTH = DEFAULT_RING_DEPTH,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [2:0]       opcode,
  input  wire logic [31:0]      timestamp_ms,
  input  wire logic [7:0]       class_byte,
  input  wire logic [7:0]       instruction_byte,
  input  wire logic [7:0]       param_one,
  input  wire logic [7:0]       param_two,
  input  wire logic [15:0]      status_word,
  input  wire logic [15:0]      event_id,
  input  wire logic [6:0]       read_index,
  output wr_req_t               wr,
  output logic [PTR_W-1:0]      wr_addr,
  output entry_t                wr_data,
  output logic                  rd_en,
  output logic [PTR_W-1:0]      rd_addr,
  output read_info_t            rd_info
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int W     = CMP_W + 1;

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] last_addr;
  logic [CNT_W-1:0] fill;
  logic [1:0]       last_kind;
  logic [7:0]       last_ins;
  logic [15:0]      last_rep;
  logic             pending;
  logic             hit;
  logic [7:0]       used;

  logic             collapse;
  logic             take;
  logic [W-1:0]     wp_w;
  logic [W-1:0]     fill_w;
  logic [W-1:0]     depth_w;
  logic [W-1:0]     idx_w;
  logic [W-1:0]     start_w;
  logic [W-1:0]     sum_w;
  logic [W-1:0]     slot_w;
  logic [CMP_W-1:0] fill_ext;

  // The newest entry's kind, type and repeat count are kept in registers, so a
  // collapse needs no read of the memory before its write.
  always_comb begin
    collapse = (opcode == OP_MSG) && (fill != '0) && (last_kind == KIND_MESSAGE) &&
               (last_ins == instruction_byte) && (last_rep != REPEAT_LIMIT);
    take     = 1'b0;
    wr_data  = '0;
    wr_data.stamp     = timestamp_ms;
    wr_data.rep_count = 16'd1;
    unique case (opcode)
      OP_CMD: begin
        take           = 1'b1;
        wr_data.kind   = KIND_COMMAND;
        wr_data.cls    = class_byte;
        wr_data.ins    = instruction_byte;
        wr_data.pa     = param_one;
        wr_data.pb     = param_two;
        wr_data.status = status_word;
      end
      OP_MSG: begin
        take         = !collapse;
        wr_data.kind = KIND_MESSAGE;
        wr_data.ins  = instruction_byte;
        if (collapse) begin
          wr_data.rep_count = last_rep + 16'd1;
        end
      end
      OP_EVT: begin
        take               = 1'b1;
        wr_data.kind       = KIND_EVENT;
        wr_data.event_code = event_id;
      end
      default: begin
        take = 1'b0;
      end
    endcase
    wr.hdr_we = accept && take;
    wr.we     = accept && (take || collapse);
    wr_addr   = collapse ? last_addr : wp;
  end

  // Slot of the read: (write pointer - fill + index) modulo the depth.
  always_comb begin
    wp_w     = W'(wp);
    fill_w   = W'(fill);
    depth_w  = W'(DEPTH);
    idx_w    = W'(read_index);
    start_w  = (wp_w >= fill_w) ? (wp_w - fill_w) : (wp_w + depth_w - fill_w);
    sum_w    = start_w + idx_w;
    slot_w   = (sum_w >= depth_w) ? (sum_w - depth_w) : sum_w;
    rd_addr  = slot_w[PTR_W-1:0];
    rd_en    = accept && (opcode == OP_READ);
    fill_ext = CMP_W'(fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      fill    <= '0;
      pending <= 1'b0;
    end else begin
      pending <= rd_en;
      if (accept && opcode == OP_CLEAR) begin
        wp   <= '0;
        fill <= '0;
      end else if (wr.hdr_we) begin
        wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
        if (fill != CNT_W'(DEPTH)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      last_kind <= wr_data.kind;
      last_ins  <= wr_data.ins;
      last_rep  <= wr_data.rep_count;
      last_addr <= wr_addr;
    end
    if (rd_en) begin
      hit  <= idx_w < fill_w;
      used <= fill_ext[7:0];
    end
  end

  always_comb begin
    rd_info.pending = pending;
    rd_info.hit     = hit;
    rd_info.used    = used;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count beyond ring depth");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    wr.hdr_we |=> (fill == $past(fill) + 1'b1) || (fill == CNT_W'(DEPTH)))
    else $error("new slot taken without fill count update");

  a_newest_rep: assert property (@(posedge clk) disable iff (rst)
    (fill != '0) |-> (last_rep != 16'd0))
    else $error("newest entry has zero repeat count");

  a_read_gap: assert property (@(posedge clk) disable iff (rst)
    pending |-> !accept)
    else $error("transaction accepted while a read is in flight");

endmodule
`default_nettype wire

[rtl/core/trace_ring_with_repeat_collapse_core.sv]
// Top level of the trace ring with repeat collapse: handshake and output register.
// A circular trace store of RING_DEPTH entries that overwrites its oldest entry. Record
// commands, message-type records, events and clears may follow one another in every
// cycle while no read is in flight; a message-type record that matches the newest entry
// raises its repeat count instead of taking a slot. The ring memory's registered read port
// delivers a read's entry in the cycle after acceptance, and the input is held off during
// that cycle. The result then sits in an output register; while it waits, further non-read
// transactions are still accepted. Reads at or beyond the fill count show zero with
// entry_valid low, and no clearing pass runs after reset.
`default_nettype none
module trace_ring_with_repeat_collapse_core import trb_pkg::*; #(
  parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] timestamp_ms,
  input  wire logic [7:0]  class_byte,
  input  wire logic [7:0]  instruction_byte,
  input  wire logic [7:0]  param_one,
  input  wire logic [7:0]  param_two,
  input  wire logic [15:0] status_word,
  input  wire logic [15:0] event_id,
  input  wire logic [6:0]  read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             entry_valid,
  output logic [1:0]       entry_kind,
  output logic [31:0]      entry_time,
  output logic [7:0]       entry_class,
  output logic [7:0]       entry_instruction,
  output logic [7:0]       entry_param_one,
  output logic [7:0]       entry_param_two,
  output logic [15:0]      entry_status,
  output logic [15:0]      entry_repeat,
  output logic [15:0]      entry_event,
  output logic [7:0]       entries_used
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic             accept;
  wr_req_t          wr;
  logic [PTR_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  entry_t           rd_data;
  read_info_t       rd_info;
  entry_t           shown;

  // A read may only start when the output register will be free as its data lands.
  assign in_ready = !rd_info.pending &&
                    (!out_valid || out_ready || (opcode != OP_READ));
  assign accept   = in_valid && in_ready;

  trb_ctrl #(.DEPTH(RING_DEPTH)) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .opcode           (opcode),
    .timestamp_ms     (timestamp_ms),
    .class_byte       (class_byte),
    .instruction_byte (instruction_byte),
    .param_one        (param_one),
    .param_two        (param_two),
    .status_word      (status_word),
    .event_id         (event_id),
    .read_index       (read_index),
    .wr               (wr),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_info          (rd_info)
  );

  trb_ring_mem #(.DEPTH(RING_DEPTH)) u_mem (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_info.pending) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // An invalid read shows zero in every entry field.
  always_ff @(posedge clk) begin
    if (rd_info.pending) begin
      entry_valid  <= rd_info.hit;
      entries_used <= rd_info.used;
      shown        <= rd_info.hit ? rd_data : '0;
    end
  end

  always_comb begin
    entry_kind        = shown.kind;
    entry_time        = shown.stamp;
    entry_class       = shown.cls;
    entry_instruction = shown.ins;
    entry_param_one   = shown.pa;
    entry_param_two   = shown.pb;
    entry_status      = shown.status;
    entry_repeat      = shown.rep_count;
    entry_event       = shown.event_code;
  end

endmodule
`default_nettype wire
